### sv/rsnp_pkg.sv
package rsnp_pkg;

    // table geometry
    localparam int MAX_ENTITIES = 256;
    localparam int IDX_W        = $clog2(MAX_ENTITIES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int COORD_W      = 32;
    localparam int ENT_W        = 3 * COORD_W;

    // configuration
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTITY_COUNT = 2'd0,
        CFG_MAX_DISTANCE = 2'd1,
        CFG_HIT_RADIUS   = 2'd2,
        CFG_SPARE        = 2'd3
    } t_cfg_idx;

    localparam logic [30:0] MAX_DIST_RST   = 31'd65536000;
    localparam logic [30:0] HIT_RADIUS_RST = 31'd32768;

    // item operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [7:0]                slot;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } t_in_item;

    typedef struct packed {
        logic       hit;
        logic [7:0] hit_index;
    } t_out_item;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_NORM  = 9'b000000010,
        ST_SQ    = 9'b000000100,
        ST_SUM   = 9'b000001000,
        ST_SQRT  = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_WALK  = 9'b001000000,
        ST_DRAIN = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

endpackage

### sv/rsnp_ram.sv
module rsnp_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ray_sphere_nearest_pick_core.sv
// Channel   Valid          Ready          Payload
// input     i_in_valid     o_in_ready     i_in   (t_in_item)
// result    o_out_valid    i_out_ready    o_out  (t_out_item)
// config    i_cfg_valid    o_cfg_ready    i_cfg_index, i_cfg_data
//
// A write item is stored on acceptance. A query first normalises the direction
// (up to 30 shifts, squares, 32-step square root, 17-step divide) and then walks
// the entity memory at one entry per cycle through an 8-stage pipeline. Reset is
// synchronous, active low, and clears control state only. A stalled result holds;
// a new item is taken in idle even while the last result waits.
module ray_sphere_nearest_pick_core
    import rsnp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state;

    // configuration registers
    logic [CNT_W-1:0] r_entity_count;
    logic [30:0]      r_max_distance;
    logic [30:0]      r_hit_radius;
    logic [61:0]      r_hr2;

    // query setup
    logic signed [COORD_W-1:0] r_org [3];
    logic [2:0]                r_neg;
    logic [31:0]               r_m [3];
    logic [63:0]               r_sq [3];
    logic [63:0]               r_v;
    logic [63:0]               r_r;
    logic [63:0]               r_bit;
    logic [4:0]                r_step;
    logic [32:0]               r_rem [3];
    logic [16:0]               r_q [3];
    logic signed [17:0]        w_u [3];
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          r_iss;

    // best so far
    logic [30:0]      r_best_t;
    logic [IDX_W-1:0] r_best;
    logic             r_found;

    // result register
    logic      r_out_valid;
    t_out_item r_out;

    // walk pipeline
    logic                r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic [IDX_W-1:0]    r_i1, r_i2, r_i3, r_i4, r_i5, r_i6, r_i7, r_i8;
    logic signed [32:0]  r_o2 [3];
    logic signed [32:0]  r_o3 [3];
    logic signed [50:0]  r_pa3 [3];
    logic signed [32:0]  r_o4 [3];
    logic signed [52:0]  r_traw4;
    logic signed [32:0]  r_o5 [3];
    logic [30:0]         r_t5, r_t6, r_t7, r_t8;
    logic signed [49:0]  r_pb5 [3];
    logic [30:0]         r_pm6 [3];
    logic [61:0]         r_sq7 [3];

    logic [ENT_W-1:0] w_rdata;
    logic             w_in_acc;
    logic             w_we;
    logic             w_issue;
    logic [IDX_W-1:0] w_raddr;
    logic             w_busy_pipe;

    // perpendicular offset terms
    logic signed [50:0] w_rnd [3];
    logic signed [35:0] w_p [3];
    logic [35:0]        w_pm [3];

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_we        = w_in_acc && (i_in.op == OP_WRITE);
    assign w_issue     = (r_state == ST_WALK) && (r_iss < r_cnt);
    assign w_raddr     = r_iss[IDX_W-1:0];
    assign w_busy_pipe = r_v1 | r_v2 | r_v3 | r_v4 | r_v5 | r_v6 | r_v7 | r_v8;

    rsnp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTITIES)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_in.slot[IDX_W-1:0]),
        .i_wdata ({i_in.pos_x, i_in.pos_y, i_in.pos_z}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entity_count <= '0;
            r_max_distance <= MAX_DIST_RST;
            r_hit_radius   <= HIT_RADIUS_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENTITY_COUNT: r_entity_count <= i_cfg_data[CNT_W-1:0];
                CFG_MAX_DISTANCE: r_max_distance <= i_cfg_data;
                CFG_HIT_RADIUS:   r_hit_radius   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // squared radius, kept up to date
    always_ff @(posedge i_clk) begin
        r_hr2 <= r_hit_radius * r_hit_radius;
    end

    // square-root and divide steps
    logic [64:0] w_trial;
    logic [32:0] w_shl [3];
    always_comb begin
        w_trial = {1'b0, r_r} + {1'b0, r_bit};
        for (int k = 0; k < 3; k++) begin
            w_shl[k] = {r_rem[k][31:0], (r_step == 5'd0) ? r_m[k][0] : 1'b0};
        end
    end

    // sequencer and setup datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && i_in.op == OP_QUERY) begin
                        r_org[0] <= i_in.pos_x;
                        r_org[1] <= i_in.pos_y;
                        r_org[2] <= i_in.pos_z;
                        r_neg    <= {i_in.dir_z[31], i_in.dir_y[31], i_in.dir_x[31]};
                        r_m[0]   <= i_in.dir_x[31] ? 32'(-i_in.dir_x) : i_in.dir_x;
                        r_m[1]   <= i_in.dir_y[31] ? 32'(-i_in.dir_y) : i_in.dir_y;
                        r_m[2]   <= i_in.dir_z[31] ? 32'(-i_in.dir_z) : i_in.dir_z;
                        r_best_t <= r_max_distance;
                        r_best   <= '0;
                        r_found  <= 1'b0;
                        r_cnt    <= (r_entity_count > CNT_W'(MAX_ENTITIES))
                                    ? CNT_W'(MAX_ENTITIES) : r_entity_count;
                        r_state  <= ST_NORM;
                    end
                end
                // shift until the largest magnitude reaches bit 30
                ST_NORM: begin
                    if ((r_m[0] | r_m[1] | r_m[2]) == '0) begin
                        r_state <= ST_DONE;
                    end else if (((r_m[0] | r_m[1] | r_m[2]) >> 30) != '0) begin
                        r_state <= ST_SQ;
                    end else begin
                        for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] << 1;
                    end
                end
                ST_SQ: begin
                    for (int k = 0; k < 3; k++) r_sq[k] <= r_m[k] * r_m[k];
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_v     <= r_sq[0] + r_sq[1] + r_sq[2];
                    r_r     <= '0;
                    r_bit   <= 64'd1 << 62;
                    r_step  <= '0;
                    r_state <= ST_SQRT;
                end
                // one root digit a cycle
                ST_SQRT: begin
                    if ({1'b0, r_v} >= w_trial) begin
                        r_v <= r_v - w_trial[63:0];
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_step == 5'd31) begin
                        r_step <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_rem[k] <= {2'b0, r_m[k][31:1]};
                            r_q[k]   <= '0;
                        end
                        r_state <= ST_DIV;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                // one quotient bit a cycle, three components side by side
                ST_DIV: begin
                    for (int k = 0; k < 3; k++) begin
                        if (w_shl[k] >= {1'b0, r_r[31:0]}) begin
                            r_rem[k] <= w_shl[k] - {1'b0, r_r[31:0]};
                            r_q[k]   <= {r_q[k][15:0], 1'b1};
                        end else begin
                            r_rem[k] <= w_shl[k];
                            r_q[k]   <= {r_q[k][15:0], 1'b0};
                        end
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd16) begin
                        r_iss   <= '0;
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (w_issue) begin
                        r_iss <= r_iss + CNT_W'(1);
                    end else begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!w_busy_pipe) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid     <= 1'b1;
                        r_out.hit       <= r_found;
                        r_out.hit_index <= 8'(r_best);
                        r_state         <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // nearest hit, in index order
            if (r_v8 && r_t8 < r_best_t) begin
                r_best_t <= r_t8;
                r_best   <= r_i8;
                r_found  <= 1'b1;
            end
        end
    end

    // signed unit direction, settled before the walk
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_u[k] = r_neg[k] ? -$signed({1'b0, r_q[k]}) : $signed({1'b0, r_q[k]});
        end
    end

    // walk pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8} <= '0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4 && !r_traw4[52]
                    && ((r_traw4 >>> 16) < $signed({22'd0, r_max_distance}));
            r_v6 <= r_v5 && (w_pm[0] <= {5'd0, r_hit_radius})
                    && (w_pm[1] <= {5'd0, r_hit_radius})
                    && (w_pm[2] <= {5'd0, r_hit_radius});
            r_v7 <= r_v6;
            r_v8 <= r_v7 && ({2'b0, r_sq7[0]} + {2'b0, r_sq7[1]} + {2'b0, r_sq7[2]}
                             <= {2'b0, r_hr2});
        end
    end

    // perpendicular offset magnitudes
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rnd[k] = 51'(r_pb5[k]) + 51'sd32768;
            w_p[k]   = 36'(r_o5[k]) - 36'(w_rnd[k] >>> 16);
            w_pm[k]  = w_p[k][35] ? 36'(-w_p[k]) : 36'(w_p[k]);
        end
    end

    // walk pipeline data
    logic signed [31:0] w_ent [3];
    assign w_ent[0] = w_rdata[3*COORD_W-1:2*COORD_W];
    assign w_ent[1] = w_rdata[2*COORD_W-1:COORD_W];
    assign w_ent[2] = w_rdata[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        r_i1 <= w_raddr;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_i4 <= r_i3;
        r_i5 <= r_i4;
        r_i6 <= r_i5;
        r_i7 <= r_i6;
        r_i8 <= r_i7;
        for (int k = 0; k < 3; k++) begin
            r_o2[k]  <= 33'(w_ent[k]) - 33'(r_org[k]);
            r_o3[k]  <= r_o2[k];
            r_pa3[k] <= 51'(r_o2[k]) * 51'(w_u[k]);
            r_o4[k]  <= r_o3[k];
            r_o5[k]  <= r_o4[k];
            r_pb5[k] <= 50'(w_u[k]) * 50'($signed({1'b0, r_traw4[46:16]}));
            r_pm6[k] <= w_pm[k][30:0];
            r_sq7[k] <= r_pm6[k] * r_pm6[k];
        end
        r_traw4 <= 53'(r_pa3[0]) + 53'(r_pa3[1]) + 53'(r_pa3[2]);
        r_t5    <= r_traw4[46:16];
        r_t6    <= r_t5;
        r_t7    <= r_t6;
        r_t8    <= r_t7;
    end

endmodule

### sv/rsnp_checker.sv
module rsnp_checker
    import rsnp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_in_item              i_in,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // a miss names index zero
    a_miss_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.hit |-> o_out.hit_index == '0)
        else $error("miss with non-zero index");

    // a query keeps the input closed while it runs
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.op == OP_QUERY |=> !o_in_ready)
        else $error("input open during query");

    // a write item makes no result
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.op == OP_WRITE && !o_out_valid
        |=> !o_out_valid)
        else $error("result after write item");

endmodule

bind ray_sphere_nearest_pick_core rsnp_checker u_rsnp_checker (.*);

### test/rsnp_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register channels of the pick core, keeps its
// own copy of the entity table and registers, and checks each result item.
module rsnp_scoreboard
    import rsnp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_queries,
    output int                    o_hits
);

    logic signed [COORD_W-1:0] centre_x [MAX_ENTITIES];
    logic signed [COORD_W-1:0] centre_y [MAX_ENTITIES];
    logic signed [COORD_W-1:0] centre_z [MAX_ENTITIES];
    logic [8:0]                entity_count;
    logic [30:0]               max_distance;
    logic [30:0]               hit_radius;
    t_out_item                 expected_picks [$];

    // floor square root, bit by bit
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // nearest entity along the ray of a query item
    function automatic t_out_item pick_nearest(t_in_item q);
        longint          org [3];
        longint          dir [3];
        longint          unit_dir [3];
        longint unsigned m [3];
        longint unsigned mx, s, r2, d2, pm;
        longint          off [3];
        longint          traw, t, best_t, p, quo;
        int              n;
        bit              found, near_ok;
        logic [7:0]      best;
        t_out_item       res;
        org[0] = longint'($signed(q.pos_x));
        org[1] = longint'($signed(q.pos_y));
        org[2] = longint'($signed(q.pos_z));
        dir[0] = longint'($signed(q.dir_x));
        dir[1] = longint'($signed(q.dir_y));
        dir[2] = longint'($signed(q.dir_z));
        res = '0;
        for (int k = 0; k < 3; k++) m[k] = (dir[k] < 0) ? -dir[k] : dir[k];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        // zero direction misses outright
        if (mx == 0) return res;
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
        end
        s = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int k = 0; k < 3; k++) begin
            quo = longint'((m[k] << 16) / s);
            unit_dir[k] = (dir[k] < 0) ? -quo : quo;
        end
        n = (entity_count > MAX_ENTITIES) ? MAX_ENTITIES : int'(entity_count);
        r2 = longint'(hit_radius) * longint'(hit_radius);
        best_t = longint'(max_distance);
        found = 0;
        best = '0;
        for (int i = 0; i < n; i++) begin
            off[0] = longint'(centre_x[i]) - org[0];
            off[1] = longint'(centre_y[i]) - org[1];
            off[2] = longint'(centre_z[i]) - org[2];
            traw = off[0] * unit_dir[0] + off[1] * unit_dir[1] + off[2] * unit_dir[2];
            // behind the origin
            if (traw < 0) continue;
            t = traw >>> 16;
            // beyond the limit, or no nearer than the best so far
            if (t >= best_t) continue;
            d2 = 0;
            near_ok = 1;
            for (int k = 0; k < 3; k++) begin
                p = off[k] - ((unit_dir[k] * t + 32768) >>> 16);
                pm = (p < 0) ? -p : p;
                if (pm > longint'(hit_radius)) near_ok = 0;
                else d2 = d2 + pm * pm;
            end
            if (!near_ok || d2 > r2) continue;
            best_t = t;
            best = i[7:0];
            found = 1;
        end
        res.hit = found;
        res.hit_index = found ? best : 8'd0;
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_queries = 0;
        o_hits = 0;
    end

    // handshakes are sampled mid-cycle, where nothing changes
    always @(negedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            entity_count = '0;
            max_distance = MAX_DIST_RST;
            hit_radius = HIT_RADIUS_RST;
            expected_picks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ENTITY_COUNT: entity_count = i_cfg_data[8:0];
                    CFG_MAX_DISTANCE: max_distance = i_cfg_data;
                    CFG_HIT_RADIUS:   hit_radius = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_picks.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("result item with none expected: hit=%0d index=%0d",
                                 i_out.hit, i_out.hit_index);
                end else begin
                    want = expected_picks.pop_front();
                    if (want.hit) o_hits++;
                    if (i_out.hit !== want.hit || i_out.hit_index !== want.hit_index) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("pick mismatch: expected hit=%0d index=%0d, %s%0d index=%0d",
                                     want.hit, want.hit_index, "got hit=",
                                     i_out.hit, i_out.hit_index);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in.op == OP_WRITE) begin
                    centre_x[i_in.slot] = i_in.pos_x;
                    centre_y[i_in.slot] = i_in.pos_y;
                    centre_z[i_in.slot] = i_in.pos_z;
                end else begin
                    expected_picks = {expected_picks, pick_nearest(i_in)};
                    o_queries++;
                end
            end
        end
        o_pending = expected_picks.size();
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rsnp_pkg::*;

    localparam int U          = 65536;
    localparam int CYCLE_CAP  = 1000000;
    localparam int SETTLE     = 400;
    localparam int HOLD_LEN   = 4000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count, pending, queries, hits;
    bit                    calm;
    bit                    hold_req;
    logic signed [31:0]    tab_x [MAX_ENTITIES];
    logic signed [31:0]    tab_y [MAX_ENTITIES];
    logic signed [31:0]    tab_z [MAX_ENTITIES];
    int                    cycles;

    ray_sphere_nearest_pick_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rsnp_scoreboard chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_queries    (queries),
        .o_hits       (hits)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                hold_req = 0;
                for (int c = 0; c < HOLD_LEN; c++) @(posedge i_clk);
            end
            out_ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    // offer one item and wait until it is taken
    task automatic send_item(input t_in_item it);
        bit taken;
        while (!calm && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        if (it.op == OP_WRITE) begin
            tab_x[it.slot] = it.pos_x;
            tab_y[it.slot] = it.pos_y;
            tab_z[it.slot] = it.pos_z;
        end
        do begin
            @(negedge i_clk);
            taken = in_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        do begin
            @(negedge i_clk);
            taken = cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        cfg_valid <= 1'b0;
    endtask

    // all results in, then let any trailing write settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_in_item store_centre(input logic [7:0] slot,
                                             input logic [31:0] x, y, z);
        t_in_item it;
        it = '0;
        it.op = OP_WRITE;
        it.slot = slot;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.dir_x = $urandom;
        it.dir_y = $urandom;
        it.dir_z = $urandom;
        return it;
    endfunction

    function automatic t_in_item ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
        t_in_item it;
        it.op = OP_QUERY;
        it.slot = 8'($urandom);
        it.pos_x = ox;
        it.pos_y = oy;
        it.pos_z = oz;
        it.dir_x = dx;
        it.dir_y = dy;
        it.dir_z = dz;
        return it;
    endfunction

    // coordinate inside a cube of about 32 units, or anything at all
    function automatic logic [31:0] coord();
        if ($urandom_range(9) == 0) return $urandom;
        return 32'(int'($urandom_range(2097152)) - 1048576);
    endfunction

    function automatic t_in_item random_item(input int n_live);
        logic [31:0] ox, oy, oz, dx, dy, dz;
        int          j, sh;
        if ($urandom_range(2) == 0)
            return store_centre(8'($urandom_range(n_live - 1)), coord(), coord(), coord());
        ox = coord();
        oy = coord();
        oz = coord();
        case ($urandom_range(9))
            0: begin
                dx = $urandom; dy = $urandom; dz = $urandom;
            end
            1: begin
                dx = '0; dy = '0; dz = '0;
            end
            2: begin
                dx = $urandom_range(3) - 1; dy = $urandom_range(3) - 1;
                dz = $urandom_range(3) - 1;
            end
            default: begin
                // aim at a stored centre, with a little jitter
                j = $urandom_range(n_live - 1);
                sh = $urandom_range(8);
                dx = ($signed(tab_x[j] - ox) >>> sh) + $urandom_range(64) - 32;
                dy = ($signed(tab_y[j] - oy) >>> sh) + $urandom_range(64) - 32;
                dz = ($signed(tab_z[j] - oz) >>> sh) + $urandom_range(64) - 32;
            end
        endcase
        return ray(ox, oy, oz, dx, dy, dz);
    endfunction

    task automatic random_phase(input int n, input int max_dist,
                                input int rad, input int len);
        wait_idle();
        write_reg(CFG_ENTITY_COUNT, n);
        write_reg(CFG_MAX_DISTANCE, max_dist);
        write_reg(CFG_HIT_RADIUS, rad);
        for (int k = 0; k < len; k++) send_item(random_item(MAX_ENTITIES));
    endtask

    initial begin
        cycles = 0;
        calm = 0;
        hold_req = 0;
        i_rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ENTITY_COUNT;
        cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: nine entries, slots 0 to 7 and 255, count still zero after reset
        send_item(store_centre(8'd0, 5 * U, 0, 0));
        send_item(store_centre(8'd1, 3 * U, U / 4, 0));
        send_item(store_centre(8'd2, -4 * U, 0, 0));
        send_item(store_centre(8'd3, 2000 * U, 0, 0));
        send_item(store_centre(8'd4, 7 * U, 0, 0));
        send_item(store_centre(8'd5, 7 * U, 0, 0));
        send_item(store_centre(8'd6, 4 * U, 3 * U, 0));
        send_item(store_centre(8'd7, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
        send_item(store_centre(8'd255, 32'h80000000, 32'h7fffffff, 32'h80000000));
        send_item(ray(0, 0, 0, U, 0, 0));
        send_item(ray(0, 0, 0, 0, 0, 0));

        wait_idle();
        write_reg(CFG_ENTITY_COUNT, 8);
        write_reg(CFG_HIT_RADIUS, U);
        // nearest along +x, tiny and huge directions, behind, tie, zero direction
        send_item(ray(0, 0, 0, U, 0, 0));
        send_item(ray(0, 0, 0, 1, 0, 0));
        send_item(ray(0, 0, 0, 32'h7fffffff, 0, 0));
        send_item(ray(0, 0, 0, 32'h80000000, 0, 0));
        send_item(ray(10 * U, 0, 0, -U, 0, 0));
        send_item(ray(0, 0, 0, 4 * U, 3 * U, 0));
        send_item(ray(0, 0, 0, 0, 0, 0));
        send_item(ray(32'h80000000, 32'h7fffffff, 32'h80000000,
                      32'h7fffffff, 32'h80000000, 32'h7fffffff));
        send_item(ray(-U, -U, -U, 32'hffffffff, 32'hffffffff, 32'hffffffff));

        // a zero distance limit rejects everything; with a zero radius only centres on the ray can hit
        wait_idle();
        write_reg(CFG_MAX_DISTANCE, 0);
        send_item(ray(0, 0, 0, U, 0, 0));
        wait_idle();
        write_reg(CFG_MAX_DISTANCE, 32'h7fffffff);
        write_reg(CFG_HIT_RADIUS, 0);
        send_item(ray(0, 0, 0, U, 0, 0));

        // fill the whole table in shuffled order
        begin
            int order [MAX_ENTITIES];
            for (int k = 0; k < MAX_ENTITIES; k++) order[k] = k;
            order.shuffle();
            for (int k = 0; k < MAX_ENTITIES; k++)
                send_item(store_centre(8'(order[k]), coord(), coord(), coord()));
        end

        // long hold-off on results while items keep coming
        hold_req = 1;
        random_phase(256, 32'h7fffffff, 32'h7fffffff, 40);
        calm = 1;
        random_phase(511, 65536000, 4 * U, 40);
        calm = 0;
        random_phase(1, 32'h7fffffff, 0, 25);
        random_phase(0, 100 * U, U, 20);
        random_phase(37, 20 * U, 8 * U, 40);
        random_phase(200, 64 * U, 2 * U, 45);
        wait_idle();

        $display("ran %0d queries (%0d hits) over %0d cycles, with several register settings",
                 queries, hits, cycles);
        $display("including extreme counts, limits and radii, and a long result stall");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
sv/rsnp_pkg.sv
sv/rsnp_ram.sv
sv/ray_sphere_nearest_pick_core.sv
sv/rsnp_checker.sv
test/rsnp_checker.sv
test/testbench.sv
